### rtl/core/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// shared constants for the homogeneous point transform
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEFF_WIDTH_DEF = 16;
    // fraction bits of a coordinate (q16.16)
    localparam int COORD_FRAC      = 16;
    // integer bits of a coefficient (q4.12 at 16 bits)
    localparam int COEFF_INT       = 4;
    localparam int NUM_ROWS        = 4;
    localparam int NUM_COLS        = 4;
    localparam int ROW_WIDTH       = 64;
    localparam int APB_ADDR_WIDTH  = 5;
    localparam int APB_DATA_WIDTH  = 64;

    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;
    localparam logic [1:0] REG_ROW3 = 2'd3;

endpackage

### rtl/core/homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 matrix point transform with perspective divide
// ----------------------------------------------------------------------------
// Takes one q16.16 point per cycle and returns one result per cycle while
// the output is not stalled. Its stages: three multiply/add stages, one
// sign/magnitude stage, one restoring divide stage per quotient bit
// (COORD_WIDTH + 1) and the output buffer. The three coordinates share the
// divisor w and are divided side by side. A stalled output fills a
// two-word buffer, then the whole pipeline holds.
module homogeneous_point_transform #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
    parameter int COEFF_WIDTH = hpt_pkg::COEFF_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // x, y, z from bit 0 up, zero padded to bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // out_x, out_y, out_z from bit 0 up, zero padded to bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
    // w_zero, overflowed from bit 0 up
    output logic [1:0]                            m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hpt_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [hpt_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [hpt_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready
);

    localparam int TDW   = ((3*COORD_WIDTH+7)/8)*8;
    localparam int SUM_W = (COORD_WIDTH + COEFF_WIDTH + 2 > 64)
                           ? 64 : COORD_WIDTH + COEFF_WIDTH + 2;
    localparam int BUF_W = 3*COORD_WIDTH + 2;
    localparam int NR    = hpt_pkg::NUM_ROWS;
    localparam logic [hpt_pkg::ROW_WIDTH-1:0] ONE =
        hpt_pkg::ROW_WIDTH'(1) << (COEFF_WIDTH - hpt_pkg::COEFF_INT);

    logic [hpt_pkg::ROW_WIDTH-1:0] row_reg [NR];
    logic [1:0]                    reg_idx;
    logic                          ce;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NR; r++) row_reg[r] <= ONE << (r*COEFF_WIDTH);
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                hpt_pkg::REG_ROW0: row_reg[0] <= pwdata;
                hpt_pkg::REG_ROW1: row_reg[1] <= pwdata;
                hpt_pkg::REG_ROW2: row_reg[2] <= pwdata;
                hpt_pkg::REG_ROW3: row_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hpt_pkg::REG_ROW0: prdata = row_reg[0];
            hpt_pkg::REG_ROW1: prdata = row_reg[1];
            hpt_pkg::REG_ROW2: prdata = row_reg[2];
            hpt_pkg::REG_ROW3: prdata = row_reg[3];
            default:           prdata = '0;
        endcase
    end

    logic                     mac_valid;
    logic signed [SUM_W-1:0]  mac_sum [NR];
    logic                     div_valid, div_wz, div_ovf;
    logic [COORD_WIDTH-1:0]   div_coord [3];
    logic [BUF_W-1:0]         buf_out;

    assign s_tready = ce;

    hpt_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEFF_WIDTH (COEFF_WIDTH),
        .SUM_WIDTH   (SUM_W)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_x      (s_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
        .in_y      (s_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
        .in_z      (s_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
        .rows      (row_reg),
        .out_valid (mac_valid),
        .out_sum   (mac_sum)
    );

    hpt_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .SUM_WIDTH   (SUM_W)
    ) u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ce             (ce),
        .in_valid       (mac_valid),
        .in_sum         (mac_sum),
        .out_valid      (div_valid),
        .out_coord      (div_coord),
        .out_w_zero     (div_wz),
        .out_overflowed (div_ovf)
    );

    hpt_skid #(
        .WIDTH (BUF_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (div_valid && ce),
        .push_data ({div_ovf, div_wz, div_coord[2], div_coord[1], div_coord[0]}),
        .has_room  (ce),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (buf_out)
    );

    assign m_tdata = TDW'(buf_out[3*COORD_WIDTH-1:0]);
    assign m_tuser = buf_out[BUF_W-1 -: 2];

endmodule

### rtl/core/hpt_mac.sv
// ----------------------------------------------------------------------------
// hpt_mac
// matrix times (x, y, z, 1): product stage, pair-sum stage, final-sum stage
// ----------------------------------------------------------------------------
module hpt_mac #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
    parameter int COEFF_WIDTH = hpt_pkg::COEFF_WIDTH_DEF,
    parameter int SUM_WIDTH   = COORD_WIDTH + COEFF_WIDTH + 2
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  ce,
    input  logic                                  in_valid,
    input  logic signed [COORD_WIDTH-1:0]         in_x,
    input  logic signed [COORD_WIDTH-1:0]         in_y,
    input  logic signed [COORD_WIDTH-1:0]         in_z,
    input  logic [hpt_pkg::ROW_WIDTH-1:0]         rows [hpt_pkg::NUM_ROWS],
    output logic                                  out_valid,
    output logic signed [SUM_WIDTH-1:0]           out_sum [hpt_pkg::NUM_ROWS]
);

    localparam int PROD_WIDTH = COORD_WIDTH + COEFF_WIDTH;
    localparam int NR = hpt_pkg::NUM_ROWS;

    logic signed [SUM_WIDTH-1:0] prod_reg  [NR][hpt_pkg::NUM_COLS];
    logic signed [SUM_WIDTH-1:0] prod_next [NR][hpt_pkg::NUM_COLS];
    logic signed [SUM_WIDTH-1:0] pa_reg    [NR];
    logic signed [SUM_WIDTH-1:0] pb_reg    [NR];
    logic signed [SUM_WIDTH-1:0] sum_reg   [NR];
    logic                        v1_reg, v2_reg, v3_reg;

    always_comb begin
        logic signed [COEFF_WIDTH-1:0] c0, c1, c2, c3;
        logic signed [PROD_WIDTH-1:0]  p0, p1, p2;
        logic signed [SUM_WIDTH-1:0]   k;
        for (int r = 0; r < NR; r++) begin
            c0 = rows[r][0*COEFF_WIDTH +: COEFF_WIDTH];
            c1 = rows[r][1*COEFF_WIDTH +: COEFF_WIDTH];
            c2 = rows[r][2*COEFF_WIDTH +: COEFF_WIDTH];
            c3 = rows[r][3*COEFF_WIDTH +: COEFF_WIDTH];
            p0 = c0 * in_x;
            p1 = c1 * in_y;
            p2 = c2 * in_z;
            k  = SUM_WIDTH'(c3);
            prod_next[r][0] = SUM_WIDTH'(p0);
            prod_next[r][1] = SUM_WIDTH'(p1);
            prod_next[r][2] = SUM_WIDTH'(p2);
            prod_next[r][3] = k <<< hpt_pkg::COORD_FRAC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_next;
            for (int r = 0; r < NR; r++) begin
                pa_reg[r]  <= prod_reg[r][0] + prod_reg[r][1];
                pb_reg[r]  <= prod_reg[r][2] + prod_reg[r][3];
                sum_reg[r] <= pa_reg[r] + pb_reg[r];
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_sum   = sum_reg;

endmodule

### rtl/core/hpt_div.sv
// ----------------------------------------------------------------------------
// hpt_div
// perspective divide: sign/magnitude stage, one restoring quotient bit per
// stage for three lanes sharing the divisor, saturation on the way out
// ----------------------------------------------------------------------------
module hpt_div #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
    parameter int SUM_WIDTH   = COORD_WIDTH + 18
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic signed [SUM_WIDTH-1:0]   in_sum [hpt_pkg::NUM_ROWS],
    output logic                          out_valid,
    output logic [COORD_WIDTH-1:0]        out_coord [3],
    output logic                          out_w_zero,
    output logic                          out_overflowed
);

    localparam int QB = COORD_WIDTH + 1;
    localparam int DW = SUM_WIDTH + QB;
    localparam int NL = 3;

    logic [DW-1:0]          rem_reg [QB+1][NL];
    logic [QB-1:0]          q_reg   [QB+1][NL];
    logic                   neg_reg [QB+1][NL];
    logic                   pre_reg [QB+1][NL];
    logic [SUM_WIDTH-1:0]   dm_reg  [QB+1];
    logic                   wz_reg  [QB+1];
    logic                   v_reg   [QB+1];

    // stage 0: magnitudes, zero w and early overflow
    always_ff @(posedge aclk) begin
        logic [SUM_WIDTH-1:0] nm, dm;
        logic [DW-1:0]        num;
        logic signed [SUM_WIDTH-1:0] w;
        if (ce) begin
            w  = in_sum[3];
            dm = w[SUM_WIDTH-1] ? SUM_WIDTH'(-w) : SUM_WIDTH'(w);
            dm_reg[0] <= dm;
            wz_reg[0] <= (w == '0);
            for (int l = 0; l < NL; l++) begin
                nm  = in_sum[l][SUM_WIDTH-1] ? SUM_WIDTH'(-in_sum[l])
                                             : SUM_WIDTH'(in_sum[l]);
                num = DW'(nm) << hpt_pkg::COORD_FRAC;
                rem_reg[0][l] <= num;
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= in_sum[l][SUM_WIDTH-1] ^ w[SUM_WIDTH-1];
                pre_reg[0][l] <= (num >= (DW'(dm) << QB));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QB; k++) v_reg[k] <= 1'b0;
        end else if (ce) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < QB; k++) v_reg[k+1] <= v_reg[k];
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int BIT = QB - 1 - k;
        logic [DW-1:0] dsh;
        assign dsh = DW'(dm_reg[k]) << BIT;
        always_ff @(posedge aclk) begin
            if (ce) begin
                dm_reg[k+1] <= dm_reg[k];
                wz_reg[k+1] <= wz_reg[k];
                for (int l = 0; l < NL; l++) begin
                    neg_reg[k+1][l] <= neg_reg[k][l];
                    pre_reg[k+1][l] <= pre_reg[k][l];
                    if (rem_reg[k][l] >= dsh) begin
                        rem_reg[k+1][l] <= rem_reg[k][l] - dsh;
                        q_reg[k+1][l]   <= {q_reg[k][l][QB-2:0], 1'b1};
                    end else begin
                        rem_reg[k+1][l] <= rem_reg[k][l];
                        q_reg[k+1][l]   <= {q_reg[k][l][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // saturate and apply sign; force zero when w is zero
    always_comb begin
        logic [QB-1:0] half;
        logic          any_sat;
        logic          sat;
        half    = QB'(1) << (COORD_WIDTH - 1);
        any_sat = 1'b0;
        for (int l = 0; l < NL; l++) begin
            if (neg_reg[QB][l]) begin
                sat = pre_reg[QB][l] || (q_reg[QB][l] > half);
                out_coord[l] = sat ? half[COORD_WIDTH-1:0]
                                   : COORD_WIDTH'(-q_reg[QB][l]);
            end else begin
                sat = pre_reg[QB][l] || (q_reg[QB][l] > (half - QB'(1)));
                out_coord[l] = sat ? COORD_WIDTH'(half - QB'(1))
                                   : q_reg[QB][l][COORD_WIDTH-1:0];
            end
            if (wz_reg[QB]) out_coord[l] = '0;
            any_sat = any_sat | sat;
        end
        out_w_zero     = wz_reg[QB];
        out_overflowed = any_sat & ~wz_reg[QB];
    end

    assign out_valid = v_reg[QB];

endmodule

### rtl/core/hpt_skid.sv
// ----------------------------------------------------------------------------
// hpt_skid
// two-word output buffer; the pipeline advances while a slot is free
// ----------------------------------------------------------------------------
module hpt_skid #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             has_room,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != 2'd0);
    assign has_room = (count_reg != 2'd2);

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign m_data = mem[rd_ptr_reg];

endmodule
